/* hdl/bodp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered dither palette package
// Shared types, register indexes and the Bayer threshold function.
// ----------------------------------------------------------------------------
package bodp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_COLOR_MODE = 2'd0;
  localparam logic [1:0] CFG_IDX_ROW_PIXELS = 2'd1;
  localparam logic [1:0] CFG_IDX_START_ROW  = 2'd2;

  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned ROW_PIXELS_W = 13;

  // Reset values of the configuration registers.
  localparam logic                    COLOR_MODE_RST = 1'b1;
  localparam logic [ROW_PIXELS_W-1:0] ROW_PIXELS_RST = 13'd640;
  localparam logic [3:0]              START_ROW_RST  = 4'd0;

  typedef enum logic {
    MODE_8_COLOUR   = 1'b0,
    MODE_256_COLOUR = 1'b1
  } color_mode_e;

  typedef struct packed {
    color_mode_e             color_mode;
    logic [ROW_PIXELS_W-1:0] row_pixels;
    logic [3:0]              start_row;
  } cfg_t;

  // Field order matches tdata from the top bits down: red, green, blue.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Recursive 16x16 Bayer threshold at table row y, table column x.
  function automatic logic [7:0] bayer_entry(input logic [3:0] y, input logic [3:0] x);
    logic [3:0] d;
    logic [7:0] v;
    int         i;
    d = x ^ y;
    v = '0;
    for (i = 0; i < 4; i++) begin
      v = {v[5:0], d[i], y[i]};
    end
    return v;
  endfunction

endpackage

/* hdl/bodp_pos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered dither position tracker
// Keeps the column and row phase of the pixel stream and gives the threshold.
// ----------------------------------------------------------------------------
module bodp_pos #(
  parameter int unsigned MATRIX_SIZE    = 16,
  parameter int unsigned MAX_ROW_PIXELS = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bodp_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic          frame_start_i,
  output logic [7:0]    threshold_o
);
  import bodp_pkg::*;

  localparam int unsigned PW   = $clog2(MATRIX_SIZE);
  localparam int unsigned CW   = $clog2(MAX_ROW_PIXELS);
  localparam int unsigned LW   = CW + 1;
  localparam int unsigned CMPW = (LW > ROW_PIXELS_W) ? LW : ROW_PIXELS_W;
  localparam logic [PW-1:0]   PHASE_LAST = PW'(MATRIX_SIZE - 1);
  localparam logic [CMPW-1:0] LEN_MAX    = CMPW'(MAX_ROW_PIXELS);

  logic [CW-1:0] col_q, col_d;
  logic [PW-1:0] cph_q, cph_d;
  logic [PW-1:0] rph_q, rph_d;

  logic [CW-1:0]   col_eff;
  logic [PW-1:0]   cph_eff, rph_eff, start_phase;
  logic [CMPW-1:0] rp_w, len_w;
  logic [LW-1:0]   len, col_inc;
  logic [4:0]      sr;

  // Start row reduced modulo the matrix size; at most eight subtractions.
  always_comb begin
    sr = {1'b0, cfg_i.start_row};
    for (int k = 0; k < 8; k++) begin
      if (sr >= 5'(MATRIX_SIZE)) begin
        sr = sr - 5'(MATRIX_SIZE);
      end
    end
    start_phase = PW'(sr);
  end

  // Row length: zero acts as one, overlong values saturate.
  always_comb begin
    rp_w = CMPW'(cfg_i.row_pixels);
    if (rp_w == '0) begin
      len_w = CMPW'(1);
    end else if (rp_w > LEN_MAX) begin
      len_w = LEN_MAX;
    end else begin
      len_w = rp_w;
    end
    len = LW'(len_w);
  end

  always_comb begin
    col_eff = frame_start_i ? '0 : col_q;
    cph_eff = frame_start_i ? '0 : cph_q;
    rph_eff = frame_start_i ? start_phase : rph_q;

    threshold_o = bayer_entry(4'(cph_eff), 4'(rph_eff));

    col_inc = LW'(col_eff) + LW'(1);
    col_d   = col_q;
    cph_d   = cph_q;
    rph_d   = rph_q;
    if (accept_i) begin
      if (col_inc >= len) begin
        col_d = '0;
        cph_d = '0;
        rph_d = (rph_eff == PHASE_LAST) ? '0 : rph_eff + PW'(1);
      end else begin
        col_d = CW'(col_inc);
        cph_d = (cph_eff == PHASE_LAST) ? '0 : cph_eff + PW'(1);
        rph_d = rph_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else begin
      col_q <= col_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

endmodule

/* hdl/bodp_quant.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered dither quantiser
// Reduces one pixel against its threshold and packs the palette index.
// ----------------------------------------------------------------------------
module bodp_quant (
  input  bodp_pkg::pixel_t      pixel_i,
  input  logic [7:0]            threshold_i,
  input  bodp_pkg::color_mode_e color_mode_i,
  output logic [7:0]            index_o
);
  import bodp_pkg::*;

  logic [10:0] r7, g7;
  logic [9:0]  b3;
  logic [8:0]  r1, g1, b1;

  always_comb begin
    r7 = 11'(pixel_i.red) * 11'd7 + 11'(threshold_i);
    g7 = 11'(pixel_i.green) * 11'd7 + 11'(threshold_i);
    b3 = 10'(pixel_i.blue) * 10'd3 + 10'(threshold_i);
    r1 = 9'(pixel_i.red) + 9'(threshold_i);
    g1 = 9'(pixel_i.green) + 9'(threshold_i);
    b1 = 9'(pixel_i.blue) + 9'(threshold_i);
    case (color_mode_i)
      MODE_256_COLOUR: index_o = {r7[10:8], g7[10:8], b3[9:8]};
      MODE_8_COLOUR:   index_o = {5'd0, r1[8], g1[8], b1[8]};
      default:         index_o = '0;
    endcase
  end

endmodule

/* hdl/bayer_ordered_dither_palette_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bayer ordered dither palette reducer
// Turns a stream of 24-bit pixels into 8-bit palette indices.
// ----------------------------------------------------------------------------
// Pixels arrive on the slave stream: tdata carries blue, green and red bytes
// and tuser flags the first pixel of a frame, which restarts the column at
// zero and the row phase at the configured start row. Every accepted request
// yields exactly one palette index on the master stream, in order.
// The block is a two-stage pipeline: the input register captures the pixel
// with its Bayer threshold, and the result register holds the packed index.
// An accepted request is registered in the input stage and then in the result
// stage, where tvalid on the output rises. Throughput is one pixel per clock,
// limited only by the output handshake.
// When the receiver stalls, the result register holds its index and the
// input register still takes one more request; s_axis_tready falls only
// once both stages are full, and only then does the stall reach the source.
// Reset clears both stages, the column and row phase, and loads the
// configuration defaults: 256-colour mode, 640 pixels per row, start row 0.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user writes it only while the stream is idle, which the block itself does
// not enforce. A write takes effect at the next clock edge.
// ----------------------------------------------------------------------------
module bayer_ordered_dither_palette_top #(
  parameter int unsigned MATRIX_SIZE    = 16,
  parameter int unsigned MAX_ROW_PIXELS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bodp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Pixel stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
  input  logic [0:0]                    s_axis_tuser,  // frame_start[0]
  // Palette index stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata   // palette_index[7:0]
);
  import bodp_pkg::*;

  cfg_t       cfg_q;
  logic       s1_valid_q, s1_valid_d;
  pixel_t     s1_pix_q;
  logic [7:0] s1_thr_q;
  logic       m_valid_q, m_valid_d;
  logic [7:0] m_data_q;

  logic       in_accept;
  logic       out_free;
  logic [7:0] threshold;
  logic [7:0] index;

  // The result stage can load whenever it is empty or being drained.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode <= color_mode_e'(COLOR_MODE_RST);
      cfg_q.row_pixels <= ROW_PIXELS_RST;
      cfg_q.start_row  <= START_ROW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_COLOR_MODE: cfg_q.color_mode <= color_mode_e'(cfg_data_i[0]);
        CFG_IDX_ROW_PIXELS: cfg_q.row_pixels <= cfg_data_i[ROW_PIXELS_W-1:0];
        CFG_IDX_START_ROW:  cfg_q.start_row  <= cfg_data_i[3:0];
        default:            cfg_q            <= cfg_q;
      endcase
    end
  end

  // Position tracking and threshold lookup for the pixel being accepted.
  bodp_pos #(
    .MATRIX_SIZE    (MATRIX_SIZE),
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (in_accept),
    .frame_start_i (s_axis_tuser[0]),
    .threshold_o   (threshold)
  );

  bodp_quant u_quant (
    .pixel_i      (s1_pix_q),
    .threshold_i  (s1_thr_q),
    .color_mode_i (cfg_q.color_mode),
    .index_o      (index)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    m_valid_d  = m_valid_q;
    if (s_axis_tready) begin
      s1_valid_d = s_axis_tvalid;
    end
    if (out_free) begin
      m_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q <= pixel_t'(s_axis_tdata);
      s1_thr_q <= threshold;
    end
    if (out_free && s1_valid_q) begin
      m_data_q <= index;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* hdl/bodp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered dither palette port checker
// Watches the stream ports of the top level for pipeline slips.
// ----------------------------------------------------------------------------
module bodp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // With the result stage empty the input side is never blocked.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output stage empty");

  // A draining output always leaves room for a new request.
  a_ready_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output drains");

  // A fresh result stems from an accepted request that passed through the input register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without a matching request");

endmodule

bind bayer_ordered_dither_palette_top bodp_checker u_bodp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
